// ----- rtl/rtc_pkg.sv -----
package rtc_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BAD_TEMP = 3'd0,
        CFG_SAT_ADC  = 3'd1,
        CFG_OPEN     = 3'd2,
        CFG_SHORT    = 3'd3,
        CFG_MAX_ITER = 3'd4
    } t_cfg_index;

    localparam logic [15:0] RST_BAD_TEMP = 16'h8000;
    localparam logic [15:0] RST_SAT_ADC  = 16'd4095;
    localparam logic [15:0] RST_OPEN     = 16'd4090;
    localparam logic [15:0] RST_SHORT    = 16'd1500;
    localparam logic [7:0]  RST_MAX_ITER = 8'd100;

    // The square term divides by 135200 = 32 * 4225, the linear term by 10000 = 16 * 625.
    localparam logic [15:0] QUAD_DIV   = 16'd4225;
    localparam logic [15:0] QUAD_RECIP = 16'd31767;
    localparam logic [15:0] LIN_COEF   = 16'd2256;
    localparam logic [15:0] LIN_DIV    = 16'd625;
    localparam logic [15:0] LIN_RECIP  = 16'd26843;
    localparam logic signed [28:0] LIN_OFFSET = 29'sd4002249;
    localparam logic [15:0] GUESS_BASE = 16'd1600;

endpackage

// ----- rtl/rtd_temperature_convert.sv -----
// Forward item: one pass through states S_SQ to S_LD; the result is registered in S_FIN.
// Inverse item: each correction pass on the shared multiplier runs S_SQ to S_FIN, up to
// max_iterations passes (a limit of 0 acts as 1); a bad temperature code skips to S_FIN.
// One item is in work at a time and the next is accepted in the cycle after its result is
// issued; while a result waits, a new item is taken and held in its last step until then.
// Synchronous active-low reset clears the control state and loads the register defaults.
module rtd_temperature_convert (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rtc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rtc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_req_type,
    input  logic [15:0]                   i_sensor_count,
    input  logic signed [15:0]            i_temp_f,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [15:0]            o_temp_result,
    output logic [15:0]                   o_adc_result
);
    import rtc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_QA, S_QB, S_QC, S_LA, S_LB, S_LC, S_LD, S_FIN
    } t_state;

    t_state r_state;

    logic [15:0] r_bad_temp;
    logic [15:0] r_sat_adc;
    logic [15:0] r_open;
    logic [15:0] r_short;
    logic [7:0]  r_max_iter;

    logic        r_inv;
    logic        r_sat;
    logic [15:0] r_target;
    logic [15:0] r_guess;
    logic [7:0]  r_iter;
    logic [42:0] r_prod;
    logic [26:0] r_y;
    logic [14:0] r_q;
    logic        r_neg;
    logic [23:0] r_z;
    logic [14:0] r_u;

    logic [26:0] mul_a;
    logic [15:0] mul_b;
    logic [42:0] mul_p;

    logic [27:0]        quad_rem;
    logic signed [28:0] lin_num;
    logic [28:0]        lin_abs;
    logic [23:0]        lin_rem;
    logic [15:0]        lin_val;
    logic [15:0]        fwd_val;
    logic [15:0]        err;
    logic [7:0]         last_iter;
    logic               out_free;
    logic               fin_done;

    always_comb begin
        mul_a = 27'(r_guess);
        mul_b = r_guess;
        unique case (r_state)
            S_SQ: begin
                mul_a = 27'(r_guess);
                mul_b = r_guess;
            end
            S_QA: begin
                mul_a = r_prod[31:5];
                mul_b = QUAD_RECIP;
            end
            S_QB: begin
                mul_a = 27'(r_prod[41:27]);
                mul_b = QUAD_DIV;
            end
            S_QC: begin
                mul_a = 27'(r_guess);
                mul_b = LIN_COEF;
            end
            S_LB: begin
                mul_a = 27'(r_z);
                mul_b = LIN_RECIP;
            end
            S_LC: begin
                mul_a = 27'(r_prod[38:24]);
                mul_b = LIN_DIV;
            end
            default: begin
                mul_a = 27'(r_guess);
                mul_b = r_guess;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign quad_rem = {1'b0, r_y} - r_prod[27:0];
    assign lin_num  = $signed({1'b0, r_prod[27:0]}) - LIN_OFFSET;
    assign lin_abs  = lin_num[28] ? 29'(-lin_num) : 29'(lin_num);
    assign lin_rem  = r_z - r_prod[23:0];
    assign lin_val  = r_neg ? 16'(-{1'b0, r_u}) : {1'b0, r_u};

    always_comb begin
        if ((r_guess > r_open) || (r_guess < r_short)) begin
            fwd_val = r_bad_temp;
        end else begin
            fwd_val = {1'b0, r_q} + lin_val;
        end
    end

    assign err       = r_target - fwd_val;
    assign last_iter = (r_max_iter == 8'd0) ? 8'd0 : r_max_iter - 8'd1;
    assign out_free  = !o_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign fin_done  = (r_state == S_FIN) && out_free &&
                       (r_sat || !r_inv || (err == 16'd0) || (r_iter == last_iter));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
            r_bad_temp  <= RST_BAD_TEMP;
            r_sat_adc   <= RST_SAT_ADC;
            r_open      <= RST_OPEN;
            r_short     <= RST_SHORT;
            r_max_iter  <= RST_MAX_ITER;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_BAD_TEMP: r_bad_temp <= i_cfg_data;
                    CFG_SAT_ADC:  r_sat_adc  <= i_cfg_data;
                    CFG_OPEN:     r_open     <= i_cfg_data;
                    CFG_SHORT:    r_short    <= i_cfg_data;
                    CFG_MAX_ITER: r_max_iter <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (fin_done) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_inv    <= i_req_type;
                        r_target <= i_temp_f;
                        r_iter   <= 8'd0;
                        r_sat    <= 1'b0;
                        if (!i_req_type) begin
                            r_guess <= i_sensor_count;
                            r_state <= S_SQ;
                        end else if (i_temp_f == r_bad_temp) begin
                            r_sat   <= 1'b1;
                            r_state <= S_FIN;
                        end else begin
                            r_guess <= {i_temp_f[13:0], 2'b00} + GUESS_BASE;
                            r_state <= S_SQ;
                        end
                    end
                end
                S_SQ: begin
                    r_prod  <= mul_p;
                    r_state <= S_QA;
                end
                S_QA: begin
                    r_y     <= r_prod[31:5];
                    r_prod  <= mul_p;
                    r_state <= S_QB;
                end
                S_QB: begin
                    r_q     <= r_prod[41:27];
                    r_prod  <= mul_p;
                    r_state <= S_QC;
                end
                S_QC: begin
                    r_q     <= r_q + 15'(quad_rem >= 28'(QUAD_DIV));
                    r_prod  <= mul_p;
                    r_state <= S_LA;
                end
                S_LA: begin
                    r_neg   <= lin_num[28];
                    r_z     <= lin_abs[27:4];
                    r_state <= S_LB;
                end
                S_LB: begin
                    r_prod  <= mul_p;
                    r_state <= S_LC;
                end
                S_LC: begin
                    r_u     <= r_prod[38:24];
                    r_prod  <= mul_p;
                    r_state <= S_LD;
                end
                S_LD: begin
                    r_u     <= r_u + 15'(lin_rem >= 24'(LIN_DIV));
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_sat) begin
                        if (out_free) begin
                            o_temp_result <= 16'sd0;
                            o_adc_result  <= r_sat_adc;
                            r_state       <= S_IDLE;
                        end
                    end else if (!r_inv) begin
                        if (out_free) begin
                            o_temp_result <= fwd_val;
                            o_adc_result  <= 16'd0;
                            r_state       <= S_IDLE;
                        end
                    end else if ((err == 16'd0) || (r_iter == last_iter)) begin
                        if (out_free) begin
                            o_temp_result <= 16'sd0;
                            o_adc_result  <= r_guess + err;
                            r_state       <= S_IDLE;
                        end
                    end else begin
                        r_guess <= r_guess + err;
                        r_iter  <= r_iter + 8'd1;
                        r_state <= S_SQ;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    import rtc_pkg::*;

    localparam int QUIET_LIMIT = 20000;

    typedef struct packed {
        logic signed [15:0] degf;
        logic [15:0]        count;
    } t_conv_result;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    t_cfg_index         cfg_index = CFG_BAD_TEMP;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               req_type = 1'b0;
    logic [15:0]        sensor_count = '0;
    logic signed [15:0] temp_f = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [15:0] temp_result;
    logic [15:0]        adc_result;

    logic [15:0] cfg_bad_temp = RST_BAD_TEMP;
    logic [15:0] cfg_sat_adc = RST_SAT_ADC;
    logic [15:0] cfg_open = RST_OPEN;
    logic [15:0] cfg_short = RST_SHORT;
    logic [7:0]  cfg_max_iter = RST_MAX_ITER;

    t_conv_result pending_results[$];
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    rtd_temperature_convert dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_req_type     (req_type),
        .i_sensor_count (sensor_count),
        .i_temp_f       (temp_f),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_temp_result  (temp_result),
        .o_adc_result   (adc_result)
    );

    always #4 clk = ~clk;

    function automatic logic [15:0] degrees_from_count(input logic [15:0] count);
        longint a;
        longint quad;
        longint lin;
        a = {48'd0, count};
        quad = (a * a) / 135200;
        lin = (2256 * a - 4002249) / 10000;
        if (count > cfg_open || count < cfg_short) begin
            return cfg_bad_temp;
        end
        return 16'(quad + lin);
    endfunction

    function automatic logic [15:0] count_for_degrees(input logic [15:0] target);
        logic [15:0] guess;
        logic [15:0] err;
        int passes;
        if (target == cfg_bad_temp) begin
            return cfg_sat_adc;
        end
        guess = target * 16'd4 + 16'd1600;
        passes = (cfg_max_iter == 8'd0) ? 1 : int'(cfg_max_iter);
        for (int i = 0; i < passes; i++) begin
            err = target - degrees_from_count(guess);
            guess = guess + err;
            if (err == 16'd0) begin
                break;
            end
        end
        return guess;
    endfunction

    task automatic note_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("Mismatch in %s: expected %h, got %h", what, want, got);
        end
    endtask

    always @(negedge clk) begin
        out_stall <= ($urandom_range(99) < sink_idle_pct);
    end

    always @(posedge clk) begin : result_check
        t_conv_result want;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                if (req_type) begin
                    want.degf = '0;
                    want.count = count_for_degrees(temp_f);
                end else begin
                    want.degf = degrees_from_count(sensor_count);
                    want.count = '0;
                end
                pending_results.push_back(want);
            end
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    note_mismatch("unexpected item", 16'd0, 16'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (temp_result !== want.degf) begin
                        note_mismatch("temp_result", want.degf, temp_result);
                    end
                    if (adc_result !== want.count) begin
                        note_mismatch("adc_result", want.count, adc_result);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("rtd_temperature_convert test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input t_cfg_index idx, input logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            CFG_BAD_TEMP: cfg_bad_temp = data;
            CFG_SAT_ADC:  cfg_sat_adc = data;
            CFG_OPEN:     cfg_open = data;
            CFG_SHORT:    cfg_short = data;
            CFG_MAX_ITER: cfg_max_iter = data[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_config(input logic [15:0] bad, input logic [15:0] sat,
                              input logic [15:0] open_lim, input logic [15:0] short_lim,
                              input logic [15:0] iters);
        write_reg(CFG_BAD_TEMP, bad);
        write_reg(CFG_SAT_ADC, sat);
        write_reg(CFG_OPEN, open_lim);
        write_reg(CFG_SHORT, short_lim);
        write_reg(CFG_MAX_ITER, iters);
    endtask

    task automatic send_item(input logic rt, input logic [15:0] adc, input logic [15:0] degf);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        sensor_count <= adc;
        temp_f <= degf;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0) begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic test_forward_limits();
        logic [15:0] counts[7] = '{16'd0, 16'd1499, 16'd1500, 16'd2800, 16'd4090,
                                   16'd4091, 16'hFFFF};
        foreach (counts[i]) begin
            send_item(1'b0, counts[i], 16'($urandom));
        end
        wait_all_results();
    endtask

    task automatic test_inverse_search();
        logic [15:0] temps[6] = '{16'h8000, 16'hFFD3, 16'd0, 16'd300, 16'd645, 16'h7FFF};
        foreach (temps[i]) begin
            send_item(1'b1, 16'($urandom), temps[i]);
        end
        wait_all_results();
    endtask

    task automatic test_forward_overflow();
        set_config(16'h7FFF, 16'd0, 16'hFFFF, 16'd0, 16'd20);
        send_item(1'b0, 16'hFFFF, 16'h0000);
        send_item(1'b0, 16'd40000, 16'hFFFF);
        send_item(1'b0, 16'd0, 16'h1234);
        send_item(1'b1, 16'hFFFF, 16'h7FFF);
        send_item(1'b1, 16'h0000, 16'd200);
        wait_all_results();
    endtask

    task automatic test_iteration_limit();
        set_config(16'h8000, 16'hFFFF, 16'd4090, 16'd1500, 16'd0);
        send_item(1'b1, 16'd0, 16'd100);
        send_item(1'b1, 16'd0, 16'h8000);
        wait_all_results();
        write_reg(CFG_MAX_ITER, 16'hA5FF);
        send_item(1'b1, 16'd0, 16'd500);
        wait_all_results();
        write_reg(CFG_MAX_ITER, 16'd1);
        send_item(1'b1, 16'd0, 16'd100);
        wait_all_results();
        set_config(16'h0000, 16'd4095, 16'd0, 16'hFFFF, 16'd5);
        send_item(1'b0, 16'd0, 16'd0);
        send_item(1'b0, 16'hFFFF, 16'd0);
        send_item(1'b1, 16'd1000, 16'd0);
        wait_all_results();
    endtask

    task automatic test_random(input int src_pct, input int sink_pct, input int n_items);
        logic        rt;
        logic [15:0] adc;
        logic [15:0] degf;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        for (int setting = 0; setting < 4; setting++) begin
            case (setting)
                0: set_config(RST_BAD_TEMP, RST_SAT_ADC, RST_OPEN, RST_SHORT,
                              16'($urandom_range(20, 1)));
                1: set_config(16'($urandom), 16'($urandom), 16'hFFFF, 16'd0,
                              16'($urandom_range(30, 1)));
                2: set_config(16'($urandom), 16'($urandom), 16'($urandom_range(65535, 2000)),
                              16'($urandom_range(3000)), 16'($urandom_range(15)));
                default: set_config(16'($urandom), 16'($urandom), 16'($urandom),
                                    16'($urandom), 16'($urandom));
            endcase
            for (int n = 0; n < n_items / 4; n++) begin
                rt = 1'($urandom);
                case ($urandom_range(3))
                    0: adc = 16'($urandom);
                    1: adc = ($urandom_range(1) ? cfg_open : cfg_short)
                             + 16'($urandom_range(2)) - 16'd1;
                    default: adc = 16'($urandom_range(4200, 1400));
                endcase
                case ($urandom_range(4))
                    0: degf = 16'($urandom);
                    1: degf = cfg_bad_temp;
                    default: degf = 16'($urandom_range(720) - 70);
                endcase
                send_item(rt, adc, degf);
                if (n == n_items / 8 || $urandom_range(199) == 0) begin
                    wait_all_results();
                end
            end
            wait_all_results();
        end
    endtask

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        src_idle_pct = 8;
        sink_idle_pct = 75;
        test_forward_limits();
        test_inverse_search();
        test_forward_overflow();
        test_iteration_limit();
        test_random(8, 75, 568);
        test_random(75, 8, 568);
        test_random(0, 0, 568);
        wait_all_results();
        repeat (20) @(negedge clk);
        if (mismatches == 0) begin
            $display("rtd_temperature_convert test passed");
        end else begin
            $display("rtd_temperature_convert test failed");
        end
        $finish;
    end

endmodule
